// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   localparam int ORDERS_DEF = 11;
   localparam int ADDR_W     = 22;
   localparam int BYTES_W    = 23;
   localparam int ORD_W      = 4;
   localparam int BSL_W      = 4;
   localparam int DATA_W     = 32;
   localparam int PADDR_W    = 3;
   localparam int REG_IDX_W  = PADDR_W - 2;

   localparam logic [BSL_W-1:0]     BSL_RESET   = 4'd6;
   localparam logic [REG_IDX_W-1:0] REG_BSL_IDX = 1'b0;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0]  free_address;
   } req_item_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] address;
      logic [ORD_W-1:0]  order;
   } rsp_item_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_DECODE,
      CMD_PICK,
      CMD_DESC,
      CMD_SPLIT_L,
      CMD_SPLIT_R,
      CMD_UP,
      CMD_FCHK,
      CMD_MERGE,
      CMD_FSET,
      CMD_POST_OK,
      CMD_POST_FAIL
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic is_free;
      logic dec_fail;
      logic pick_fail;
      logic pick_at_k;
      logic desc_last;
      logic split_done;
      logic up_need;
      logic up_last;
      logic map_bad;
      logic fchk_top;
      logic merge_hit;
      logic merge_last;
      logic lvl_top;
      logic rsp_free;
   } status_type;

   typedef enum logic [12:0] {
      ST_CLEAR   = 13'b0000000000001,
      ST_IDLE    = 13'b0000000000010,
      ST_DECODE  = 13'b0000000000100,
      ST_PICK    = 13'b0000000001000,
      ST_DESC    = 13'b0000000010000,
      ST_SPLIT_L = 13'b0000000100000,
      ST_SPLIT_R = 13'b0000001000000,
      ST_UP      = 13'b0000010000000,
      ST_FCHK    = 13'b0000100000000,
      ST_MERGE   = 13'b0001000000000,
      ST_FSET    = 13'b0010000000000,
      ST_DONE    = 13'b0100000000000,
      ST_FAIL    = 13'b1000000000000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/bba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_datapath #(
   parameter int ORDERS = bba_pkg::ORDERS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bba_pkg::cmd_type           cmd,
   input  wire logic [bba_pkg::BSL_W-1:0]  bsl,
   input  wire bba_pkg::req_item_type      req_data,
   input  wire logic                       rsp_stall,
   output bba_pkg::status_type             status,
   output logic                            rsp_valid,
   output bba_pkg::rsp_item_type           rsp_data
);
   import bba_pkg::*;

   localparam int TOP        = ORDERS - 1;
   localparam int NODE_W     = ORDERS;
   localparam int SPAN_W     = ORDERS - 1;
   localparam int LVL_W      = $clog2(ORDERS);
   localparam int TREE_DEPTH = 1 << NODE_W;
   localparam int SPAN       = 1 << SPAN_W;
   localparam int NEED_W     = BYTES_W + 1;
   localparam int WANT_W     = $clog2(NEED_W + 1);
   localparam int SHIFT_W    = SPAN_W + 16;

   localparam logic [LVL_W-1:0]  LVL_TOP  = LVL_W'(TOP);
   localparam logic [NODE_W-1:0] NODE_ONE = NODE_W'(1);

   // One mask per tree node: bit j set when a free node of order j lies in the subtree.
   logic [ORDERS-1:0] tree_mem [TREE_DEPTH];
   logic [LVL_W:0]    map_mem  [SPAN];
   logic [ORDERS-1:0] tree_rd_ff;
   logic [LVL_W:0]    map_rd_ff;

   logic              tw_en, mw_en;
   logic [NODE_W-1:0] tw_addr, tr_addr;
   logic [ORDERS-1:0] tw_data;
   logic [SPAN_W-1:0] mw_addr, mr_addr;
   logic [LVL_W:0]    mw_data;

   req_item_type      req_ff, req_in;
   logic [LVL_W-1:0]  want_ff, want_in, k_ff, k_in, lvl_ff, lvl_in;
   logic [NODE_W-1:0] node_ff, node_in, nk_ff, nk_in, clr_ff, clr_in;
   logic [ORDERS-1:0] cur_ff, cur_in;
   logic [SPAN_W-1:0] blk_ff, blk_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [ORD_W-1:0]  res_ord_ff, res_ord_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   function automatic logic [ORDERS-1:0] below(input logic [LVL_W-1:0] n);
      logic [ORDERS-1:0] m;
      for (int i = 0; i < ORDERS; i++) begin
         m[i] = (LVL_W'(i) < n);
      end
      return m;
   endfunction

   function automatic logic [ORDERS-1:0] bit_of(input logic [LVL_W-1:0] n);
      return ORDERS'(1) << n;
   endfunction

   // decode of the request
   logic [BYTES_W-1:0] byte_mask;
   logic [NEED_W-1:0]  need, need_m1;
   logic [WANT_W-1:0]  want_c;
   logic               want_fail;
   logic [ADDR_W-1:0]  addr_mask, blk_full;
   logic               misal, oor;

   always_comb begin
      byte_mask = ~({BYTES_W{1'b1}} << bsl);
      need      = ({1'b0, req_ff.request_bytes} + {1'b0, byte_mask}) >> bsl;
      need_m1   = (need == '0) ? '0 : need - NEED_W'(1);
      want_c    = '0;
      for (int i = 0; i < NEED_W; i++) begin
         if (need_m1[i]) begin
            want_c = WANT_W'(i + 1);
         end
      end
      want_fail = (want_c >= WANT_W'(ORDERS));
      addr_mask = ~({ADDR_W{1'b1}} << bsl);
      misal     = |(req_ff.free_address & addr_mask);
      blk_full  = req_ff.free_address >> bsl;
      oor       = |(blk_full >> SPAN_W);
   end

   // search and walk helpers
   logic [ORDERS-1:0] kmask;
   logic [LVL_W-1:0]  k_c, ent_ord;
   logic [NODE_W-1:0] child, fnode, parent;
   logic [SPAN_W-1:0] start_blk;
   logic [SHIFT_W-1:0] start_wide;
   logic [ORDERS-1:0] up_mask;

   always_comb begin
      kmask = tree_rd_ff & ~below(want_ff);
      k_c   = '0;
      for (int i = ORDERS - 1; i >= 0; i--) begin
         if (kmask[i]) begin
            k_c = LVL_W'(i);
         end
      end
      child      = {node_ff[NODE_W-2:0], ~tree_rd_ff[k_ff]};
      start_blk  = SPAN_W'(node_ff << want_ff);
      start_wide = SHIFT_W'(start_blk) << bsl;
      parent     = node_ff >> 1;
      up_mask    = cur_ff | tree_rd_ff;
      ent_ord    = map_rd_ff[LVL_W-1:0];
      fnode      = (NODE_ONE << (LVL_TOP - ent_ord)) | (NODE_W'(blk_ff) >> ent_ord);
   end

   always_comb begin
      status.clr_done   = &clr_ff;
      status.is_free    = (req_ff.req_type == REQ_FREE);
      status.dec_fail   = status.is_free ? (misal | oor) : want_fail;
      status.pick_fail  = (kmask == '0);
      status.pick_at_k  = (k_c == LVL_TOP);
      status.desc_last  = (lvl_ff - LVL_W'(1) == k_ff);
      status.split_done = (lvl_ff == want_ff);
      status.up_need    = (k_ff != LVL_TOP);
      status.up_last    = (lvl_ff == LVL_TOP - LVL_W'(1));
      status.map_bad    = ~map_rd_ff[LVL_W] | (ent_ord > LVL_TOP);
      status.fchk_top   = (ent_ord == LVL_TOP);
      status.merge_hit  = tree_rd_ff[lvl_ff];
      status.merge_last = (lvl_ff == LVL_TOP - LVL_W'(1));
      status.lvl_top    = (lvl_ff == LVL_TOP);
      status.rsp_free   = ~rsp_valid_ff | ~rsp_stall;
   end

   always_comb begin
      tw_en = 1'b0; tw_addr = node_ff; tw_data = '0;
      mw_en = 1'b0; mw_addr = blk_ff;  mw_data = '0;
      tr_addr = NODE_ONE;
      mr_addr = blk_ff;
      req_in = req_ff; want_in = want_ff; k_in = k_ff; lvl_in = lvl_ff;
      node_in = node_ff; nk_in = nk_ff; cur_in = cur_ff; blk_in = blk_ff;
      res_addr_in = res_addr_ff; res_ord_in = res_ord_ff;
      clr_in = clr_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (cmd)
         CMD_CLEAR: begin
            tw_en   = 1'b1;
            tw_addr = clr_ff;
            tw_data = (clr_ff == NODE_ONE) ? bit_of(LVL_TOP) : '0;
            mw_en   = 1'b1;
            mw_addr = clr_ff[SPAN_W-1:0];
            clr_in  = clr_ff + NODE_ONE;
         end
         CMD_LOAD: req_in = req_data;
         CMD_DECODE: begin
            want_in = LVL_W'(want_c);
            blk_in  = blk_full[SPAN_W-1:0];
            mr_addr = blk_full[SPAN_W-1:0];
         end
         CMD_PICK: begin
            k_in    = k_c;
            node_in = NODE_ONE;
            nk_in   = NODE_ONE;
            lvl_in  = LVL_TOP;
            tr_addr = NODE_W'(2);
         end
         CMD_DESC: begin
            node_in = child;
            nk_in   = child;
            lvl_in  = lvl_ff - LVL_W'(1);
            tr_addr = {child[NODE_W-2:0], 1'b0};
         end
         CMD_SPLIT_L: begin
            tw_en   = 1'b1;
            tw_data = below(lvl_ff) & ~below(want_ff);
            if (lvl_ff == want_ff) begin
               mw_en       = 1'b1;
               mw_addr     = start_blk;
               mw_data     = {1'b1, want_ff};
               res_addr_in = start_wide[ADDR_W-1:0];
               res_ord_in  = ORD_W'(want_ff);
               node_in     = nk_ff;
               lvl_in      = k_ff;
               cur_in      = below(k_ff) & ~below(want_ff);
               tr_addr     = nk_ff ^ NODE_ONE;
            end
         end
         CMD_SPLIT_R: begin
            tw_en   = 1'b1;
            tw_addr = {node_ff[NODE_W-2:0], 1'b1};
            tw_data = bit_of(lvl_ff - LVL_W'(1));
            node_in = {node_ff[NODE_W-2:0], 1'b0};
            lvl_in  = lvl_ff - LVL_W'(1);
         end
         CMD_UP: begin
            tw_en   = 1'b1;
            tw_addr = parent;
            tw_data = up_mask;
            cur_in  = up_mask;
            node_in = parent;
            lvl_in  = lvl_ff + LVL_W'(1);
            tr_addr = parent ^ NODE_ONE;
         end
         CMD_FCHK: begin
            if (!status.map_bad) begin
               mw_en       = 1'b1;
               res_addr_in = req_ff.free_address;
               res_ord_in  = ORD_W'(ent_ord);
               node_in     = fnode;
               lvl_in      = ent_ord;
               tr_addr     = fnode ^ NODE_ONE;
            end
         end
         CMD_MERGE: begin
            tr_addr = node_ff ^ NODE_ONE;
            if (status.merge_hit) begin
               tw_en   = 1'b1;
               tw_addr = node_ff ^ NODE_ONE;
               node_in = parent;
               lvl_in  = lvl_ff + LVL_W'(1);
               tr_addr = parent ^ NODE_ONE;
            end
         end
         CMD_FSET: begin
            tw_en   = 1'b1;
            tw_data = bit_of(lvl_ff);
            cur_in  = bit_of(lvl_ff);
            tr_addr = node_ff ^ NODE_ONE;
         end
         CMD_POST_OK: begin
            rsp_in       = '{ok: 1'b1, address: res_addr_ff, order: res_ord_ff};
            rsp_valid_in = 1'b1;
         end
         CMD_POST_FAIL: begin
            rsp_in       = '{ok: 1'b0, address: '0, order: '0};
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tw_en) begin
         tree_mem[tw_addr] <= tw_data;
      end
      tree_rd_ff <= tree_mem[tr_addr];
   end

   always_ff @(posedge clock) begin
      if (mw_en) begin
         map_mem[mw_addr] <= mw_data;
      end
      map_rd_ff <= map_mem[mr_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      want_ff     <= want_in;
      k_ff        <= k_in;
      lvl_ff      <= lvl_in;
      node_ff     <= node_in;
      nk_ff       <= nk_in;
      cur_ff      <= cur_in;
      blk_ff      <= blk_in;
      res_addr_ff <= res_addr_in;
      res_ord_ff  <= res_ord_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/bba_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bba_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire bba_pkg::status_type status,
   output logic                     req_stall,
   output bba_pkg::cmd_type         cmd
);
   import bba_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd = CMD_DECODE;
            if (status.dec_fail)     state_in = ST_FAIL;
            else if (status.is_free) state_in = ST_FCHK;
            else                     state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd = CMD_PICK;
            if (status.pick_fail)      state_in = ST_FAIL;
            else if (status.pick_at_k) state_in = ST_SPLIT_L;
            else                       state_in = ST_DESC;
         end
         ST_DESC: begin
            cmd = CMD_DESC;
            if (status.desc_last) state_in = ST_SPLIT_L;
         end
         ST_SPLIT_L: begin
            cmd = CMD_SPLIT_L;
            if (!status.split_done)  state_in = ST_SPLIT_R;
            else if (status.up_need) state_in = ST_UP;
            else                     state_in = ST_DONE;
         end
         ST_SPLIT_R: begin
            cmd      = CMD_SPLIT_R;
            state_in = ST_SPLIT_L;
         end
         ST_UP: begin
            cmd = CMD_UP;
            if (status.up_last) state_in = ST_DONE;
         end
         ST_FCHK: begin
            cmd = CMD_FCHK;
            if (status.map_bad)       state_in = ST_FAIL;
            else if (status.fchk_top) state_in = ST_FSET;
            else                      state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd = CMD_MERGE;
            if (!status.merge_hit || status.merge_last) state_in = ST_FSET;
         end
         ST_FSET: begin
            cmd      = CMD_FSET;
            state_in = status.lvl_top ? ST_DONE : ST_UP;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd      = CMD_POST_OK;
               state_in = ST_IDLE;
            end
         end
         ST_FAIL: begin
            if (status.rsp_free) begin
               cmd      = CMD_POST_FAIL;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Buddy allocator, one transaction in flight. Allocate: descent and climb over TOP-k levels,
// split over k-want levels; free: merging climbs toward the root. Next request is taken in
// the cycle after the result posts. Synchronous active-high reset clears control, then a
// clearing pass over every tree node initializes both memories before the first request is
// taken; block_size_log2 resets to 6.

module buddy_block_allocator #(
   parameter int ORDERS = bba_pkg::ORDERS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire bba_pkg::req_item_type         req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output bba_pkg::rsp_item_type              rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bba_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [bba_pkg::DATA_W-1:0]    pwdata,
   output logic [bba_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);
   import bba_pkg::*;

   logic [BSL_W-1:0] bsl_ff, bsl_in;
   logic             reg_hit;
   cmd_type          cmd;
   status_type       status;

   // Register file: only block_size_log2, written on the access phase.
   assign reg_hit = (paddr[PADDR_W-1:2] == REG_BSL_IDX);
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? DATA_W'(bsl_ff) : '0;

   always_comb begin
      bsl_in = bsl_ff;
      if (psel && penable && pwrite && reg_hit) begin
         bsl_in = pwdata[BSL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsl_ff <= BSL_RESET;
      end else begin
         bsl_ff <= bsl_in;
      end
   end

   // Sequencer: walks the tree one level per step and hands micro-ops to the datapath.
   bba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Datapath: node-mask memory, start-order memory, walk registers, result register.
   bba_datapath #(
      .ORDERS (ORDERS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .bsl       (bsl_ff),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb_buddy_block_allocator.sv =====
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
   import bba_pkg::*;

   localparam int TOP  = ORDERS_DEF - 1;
   localparam int SPAN = 1 << TOP;
   localparam int LATENCY = 4 * ORDERS_DEF + 10;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock, reset;
   logic req_valid, req_stall;
   req_item_type req_data;
   logic rsp_valid, rsp_stall;
   rsp_item_type rsp_data;
   logic psel, penable, pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;
   logic pready;

   buddy_block_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Shadow allocator state: free bit per tree node, start-order map per block.
   bit             node_free [1:2*SPAN-1];
   bit             start_live [SPAN];
   logic [ORD_W-1:0] start_ord [SPAN];
   logic [BSL_W-1:0] shadow_bsl;

   rsp_item_type pending_rsp [$];
   int   fail_count = 0;
   longint cycle_count = 0;

   // Live allocations, by byte offset, so frees can hit real starts.
   logic [ADDR_W-1:0] live_addr [$];

   function automatic int tree_node(int ord, int idx);
      return (SPAN >> ord) + idx;
   endfunction

   function automatic rsp_item_type predict_alloc(logic [BYTES_W-1:0] bytes);
      rsp_item_type r;
      longint need;
      int want, k, i, idx, start;
      bit found;
      r = '0;
      need = (longint'(bytes) + ((64'd1 << shadow_bsl) - 1)) >> shadow_bsl;
      if (need == 0) need = 1;
      want = 0;
      while (want < ORDERS_DEF && (64'd1 << want) < need) want++;
      if (want >= ORDERS_DEF) return r;
      found = 0;
      idx = 0;
      for (k = want; k < ORDERS_DEF; k++) begin
         for (i = 0; i < (SPAN >> k); i++) begin
            if (node_free[tree_node(k, i)]) begin
               idx = i;
               found = 1;
               break;
            end
         end
         if (found) break;
      end
      if (!found) return r;
      node_free[tree_node(k, idx)] = 0;
      while (k > want) begin
         k--;
         idx = idx * 2;
         node_free[tree_node(k, idx + 1)] = 1;
      end
      start = idx << want;
      start_live[start] = 1;
      start_ord[start] = want[ORD_W-1:0];
      r.ok = 1'b1;
      r.address = ADDR_W'(longint'(start) << shadow_bsl);
      r.order = want[ORD_W-1:0];
      live_addr.push_back(r.address);
      return r;
   endfunction

   function automatic rsp_item_type predict_free(logic [ADDR_W-1:0] addr);
      rsp_item_type r;
      longint blk;
      int ord, node;
      r = '0;
      if ((longint'(addr) & ((64'd1 << shadow_bsl) - 1)) != 0) return r;
      blk = longint'(addr) >> shadow_bsl;
      if (blk >= SPAN) return r;
      if (!start_live[blk]) return r;
      ord = start_ord[blk];
      start_live[blk] = 0;
      node = tree_node(ord, int'(blk) >> ord);
      while (ord < TOP && node_free[node ^ 1]) begin
         node_free[node ^ 1] = 0;
         node >>= 1;
         ord++;
      end
      node_free[node] = 1;
      r.ok = 1'b1;
      r.address = addr;
      r.order = start_ord[blk];
      return r;
   endfunction

   function automatic rsp_item_type predict_request(req_item_type t);
      if (t.req_type == REQ_ALLOC) return predict_alloc(t.request_bytes);
      return predict_free(t.free_address);
   endfunction

   // Cycle limit and result checking.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL buddy_block_allocator");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_item_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result ok=%0b address=%0h order=%0d",
                   rsp_data.ok, rsp_data.address, rsp_data.order);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.ok !== exp_rsp.ok) begin
               $error("ok: expected %0b actual %0b", exp_rsp.ok, rsp_data.ok);
               fail_count++;
            end
            if (rsp_data.address !== exp_rsp.address) begin
               $error("address: expected %0h actual %0h", exp_rsp.address, rsp_data.address);
               fail_count++;
            end
            if (rsp_data.order !== exp_rsp.order) begin
               $error("order: expected %0d actual %0d", exp_rsp.order, rsp_data.order);
               fail_count++;
            end
         end
      end
   end

   // Receiver stall pattern: mode changes now and then, some stretches never stall.
   int stall_mode = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Drive one transaction: hold valid until accepted, then record the prediction.
   task automatic send_request(req_item_type t, bit has_exp, rsp_item_type exp_rsp);
      rsp_item_type pred;
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = predict_request(t);
      if (has_exp && pred !== exp_rsp) begin
         $error("directed row: expected %0h predicted %0h", exp_rsp, pred);
         fail_count++;
      end
      pending_rsp.push_back(pred);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      shadow_bsl = value[BSL_W-1:0];
   endtask

   function automatic req_item_type make_req(logic kind, int bytes, int addr);
      req_item_type t;
      t.req_type = kind;
      t.request_bytes = BYTES_W'(bytes);
      t.free_address = ADDR_W'(addr);
      return t;
   endfunction

   // Directed rows: request plus optional typed expectation.
   typedef struct {
      req_item_type rq;
      bit           has_exp;
      rsp_item_type exp_rsp;
   } stim_row_type;

   stim_row_type dir_rows [$];

   task automatic add_row(logic kind, int bytes, int addr, bit has_exp,
                          logic ok, int a, int o);
      stim_row_type row;
      row.rq = make_req(kind, bytes, addr);
      row.has_exp = has_exp;
      row.exp_rsp.ok = ok;
      row.exp_rsp.address = ADDR_W'(a);
      row.exp_rsp.order = ORD_W'(o);
      dir_rows.push_back(row);
   endtask

   function automatic req_item_type random_request(int max_ord);
      req_item_type t;
      int pick, ord;
      t = '0;
      t.request_bytes = BYTES_W'($urandom);
      t.free_address = ADDR_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         t.req_type = REQ_ALLOC;
         ord = $urandom_range(0, max_ord);
         t.request_bytes = BYTES_W'(($urandom_range(1, 1 << ord) << shadow_bsl)
                                   - $urandom_range(0, 1));
         if ($urandom_range(0, 15) == 0) t.request_bytes = BYTES_W'($urandom);
      end else if (pick < 90 && live_addr.size() != 0) begin
         t.req_type = REQ_FREE;
         ord = $urandom_range(0, live_addr.size() - 1);
         t.free_address = live_addr[ord];
         live_addr.delete(ord);
      end else begin
         t.req_type = REQ_FREE;
         if ($urandom_range(0, 1)) t.free_address = ADDR_W'($urandom_range(0, SPAN - 1)
                                                           << shadow_bsl);
      end
      return t;
   endfunction

   initial begin
      rsp_item_type none;
      req_item_type t;
      int burst, phase, max_ord;
      logic [BSL_W-1:0] bsl_set [6];

      bsl_set = '{4'd0, 4'd12, 4'd3, 4'd6, 4'd9, 4'd1};
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      for (int n = 1; n < 2 * SPAN; n++) node_free[n] = 0;
      for (int n = 0; n < SPAN; n++) begin
         start_live[n] = 0;
         start_ord[n] = '0;
      end
      node_free[1] = 1;
      shadow_bsl = BSL_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed rows at the reset block size of 64 bytes.
      add_row(REQ_FREE,  0, 0,       1, 0, 0, 0);   // free with nothing live
      add_row(REQ_ALLOC, 0, 0,       1, 1, 0, 0);   // zero size counts as one block
      add_row(REQ_FREE,  0, 0,       1, 1, 0, 0);
      add_row(REQ_ALLOC, 65536, 0,   1, 1, 0, 10);  // whole pool
      add_row(REQ_ALLOC, 1, 0,       1, 0, 0, 0);   // pool exhausted
      add_row(REQ_FREE,  0, 32,      1, 0, 0, 0);   // misaligned address
      add_row(REQ_FREE,  0, 64,      1, 0, 0, 0);   // not a live start
      add_row(REQ_FREE,  0, 0,       1, 1, 0, 10);
      add_row(REQ_ALLOC, 65537, 0,   1, 0, 0, 0);   // order too large
      add_row(REQ_ALLOC, 4194304, 0, 1, 0, 0, 0);   // order too large
      add_row(REQ_ALLOC, 64, 0,      1, 1, 0, 0);
      add_row(REQ_ALLOC, 65, 0,      1, 1, 128, 1);
      add_row(REQ_ALLOC, 64, 0,      1, 1, 64, 0);
      add_row(REQ_FREE,  0, 4194303, 1, 0, 0, 0);   // address all ones
      add_row(REQ_FREE,  0, 0,       0, 0, 0, 0);
      add_row(REQ_FREE,  0, 64,      0, 0, 0, 0);
      add_row(REQ_FREE,  0, 128,     0, 0, 0, 0);   // merges back to the root
      add_row(REQ_ALLOC, 8388607, 0, 1, 0, 0, 0);
      foreach (dir_rows[r]) begin
         send_request(dir_rows[r].rq, dir_rows[r].has_exp, dir_rows[r].exp_rsp);
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 5));
      end
      drain();
      live_addr.delete();

      // Random phases over several block sizes, pool drained in each so the
      // tree ends every phase whole and frees never see stale sizes.
      for (phase = 0; phase < 6; phase++) begin
         csr_write(REG_BSL_IDX, DATA_W'(bsl_set[phase]));
         max_ord = (phase == 1) ? TOP : 5;
         for (int n = 0; n < 280; n++) begin
            t = random_request(max_ord);
            send_request(t, 0, none);
            burst = $urandom_range(0, 7);
            if (burst == 0) idle_gap($urandom_range(1, 12));
            else if (burst == 1) idle_gap(1);
         end
         while (live_addr.size() != 0) begin
            t = make_req(REQ_FREE, 0, live_addr[0]);
            void'(live_addr.pop_front());
            send_request(t, 0, none);
         end
         drain();
      end
      // Free interpreted with a changed block size.
      csr_write(REG_BSL_IDX, DATA_W'(4'd4));
      send_request(make_req(REQ_ALLOC, 16, 0), 1, '{1'b1, 22'd0, 4'd0});
      drain();
      csr_write(REG_BSL_IDX, DATA_W'(4'd5));
      send_request(make_req(REQ_FREE, 0, 0), 1, '{1'b1, 22'd0, 4'd0});
      drain();

      if (fail_count == 0) begin
         $display("PASS buddy_block_allocator");
      end else begin
         $display("FAIL buddy_block_allocator");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bba_pkg.sv
rtl/bba_datapath.sv
rtl/bba_controller.sv
rtl/buddy_block_allocator.sv
tb/tb_buddy_block_allocator.sv
